### hdl/set_assoc_lru_cache_tags_assert.svh
// Assertion macros for the set-associative LRU tag store.
`ifndef SET_ASSOC_LRU_CACHE_TAGS_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_ASSERT_SVH
`ifndef SYNTH
`define SALCT_ASSERT(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define SALCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SALCT_ASSERT(lbl, clk, rst_n, cond, msg)
`define SALCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/salct_pkg.sv
// Types and constants shared by the LRU tag store modules.
package salct_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int SET_BITS_W = 3;
  localparam int OFFSET_W   = 5;
  localparam int WAYS_W     = 4;
  localparam int STAMP_W    = 64;
  localparam int CNT_W      = 32;
  localparam int Q_DEPTH    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

  localparam logic [SET_BITS_W-1:0] RST_SET_BITS = 3'd4;
  localparam logic [OFFSET_W-1:0]   RST_OFFSET   = 5'd4;
  localparam logic [WAYS_W-1:0]     RST_WAYS     = 4'd1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_IFETCH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CMP,
    BK_REDUCE,
    BK_WRITE
  } bk_state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] address;
  } in_item_t;

  typedef struct packed {
    logic             was_hit;
    logic             was_miss;
    logic             was_eviction;
    logic             extra_hit;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } out_item_t;

endpackage

### hdl/salct_front.sv
// Front end: configuration registers and classification of accesses into set and tag.
module salct_front #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_BITS    = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [salct_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [salct_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  salct_pkg::in_item_t                   in_item,
  output logic                                  q_push,
  output logic [$clog2(MAX_WAYS+1)+MAX_SET_BITS+ADDR_BITS-1:0] q_data,
  input  logic                                  q_full
);
  import salct_pkg::*;

  localparam int SB_W  = $clog2(MAX_SET_BITS + 1);
  localparam int WC_W  = $clog2(MAX_WAYS + 1);
  localparam int TAG_W = ADDR_BITS - 2;
  localparam int SUM_W = $clog2(MAX_SET_BITS + 32);

  typedef struct packed {
    op_t               op;
    logic [WC_W-1:0]   ways;
    logic [MAX_SET_BITS-1:0] set;
    logic [TAG_W-1:0]  tag;
  } q_item_t;

  logic [SET_BITS_W-1:0]   set_bits_r;
  logic [OFFSET_W-1:0]     offset_r;
  logic [WAYS_W-1:0]       ways_r;
  logic [SB_W-1:0]         s_eff;
  logic [OFFSET_W-1:0]     b_eff;
  logic [WC_W-1:0]         e_eff;
  logic [SUM_W-1:0]        sb_sum;
  logic [ADDR_BITS-1:0]    addr_l;
  logic [ADDR_BITS-1:0]    shifted;
  logic [ADDR_BITS-1:0]    tag_full;
  logic [MAX_SET_BITS-1:0] set_mask;
  q_item_t                 q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= RST_SET_BITS;
      offset_r   <= RST_OFFSET;
      ways_r     <= RST_WAYS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SET_BITS:    set_bits_r <= cfg_data[SET_BITS_W-1:0];
        CFG_OFFSET_BITS: offset_r   <= cfg_data[OFFSET_W-1:0];
        CFG_WAYS:        ways_r     <= cfg_data[WAYS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (set_bits_r == '0) begin
      s_eff = SB_W'(1);
    end else if (int'(set_bits_r) > MAX_SET_BITS) begin
      s_eff = SB_W'(MAX_SET_BITS);
    end else begin
      s_eff = SB_W'(set_bits_r);
    end
    b_eff = (offset_r == '0) ? OFFSET_W'(1) : offset_r;
    if (ways_r == '0) begin
      e_eff = WC_W'(1);
    end else if (int'(ways_r) > MAX_WAYS) begin
      e_eff = WC_W'(MAX_WAYS);
    end else begin
      e_eff = WC_W'(ways_r);
    end

    addr_l   = in_item.address[ADDR_BITS-1:0];
    shifted  = addr_l >> b_eff;
    set_mask = ~({MAX_SET_BITS{1'b1}} << s_eff);
    sb_sum   = SUM_W'(s_eff) + SUM_W'(b_eff);
    tag_full = addr_l >> sb_sum;

    q_item.op   = op_t'(in_item.opcode);
    q_item.ways = e_eff;
    q_item.set  = shifted[MAX_SET_BITS-1:0] & set_mask;
    q_item.tag  = tag_full[TAG_W-1:0];
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_data   = q_item;

endmodule

### hdl/salct_fifo.sv
// Short item queue between the front and back ends.
module salct_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### hdl/salct_back.sv
// Back end: set row memory, tag compare, LRU reduction, write back and result register.
`include "set_assoc_lru_cache_tags_assert.svh"
module salct_back #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_BITS    = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_empty,
  output logic                                  q_pop,
  input  logic [$clog2(MAX_WAYS+1)+MAX_SET_BITS+ADDR_BITS-1:0] q_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output salct_pkg::out_item_t                  out_item
);
  import salct_pkg::*;

  localparam int WC_W     = $clog2(MAX_WAYS + 1);
  localparam int TAG_W    = ADDR_BITS - 2;
  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int WI_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LVLS     = $clog2(MAX_WAYS);
  localparam int LVL_W    = (LVLS < 1) ? 1 : $clog2(LVLS + 1);
  localparam int P        = 1 << LVLS;

  typedef struct packed {
    op_t               op;
    logic [WC_W-1:0]   ways;
    logic [MAX_SET_BITS-1:0] set;
    logic [TAG_W-1:0]  tag;
  } q_item_t;

  typedef struct packed {
    logic               vld;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  typedef struct packed {
    logic               ok;
    logic [WI_W-1:0]    idx;
    logic [STAMP_W-1:0] stamp;
  } cand_t;

  function automatic cand_t pick(input cand_t a, input cand_t b);
    if (b.ok && (!a.ok || (b.stamp < a.stamp))) begin
      return b;
    end
    return a;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
    if (en && (v != '1)) begin
      return v + CNT_W'(1);
    end
    return v;
  endfunction

  row_t               mem [NUM_SETS];
  row_t               rd_row_r;
  logic               rd_rowv_r;
  logic [NUM_SETS-1:0] rowv_r;
  row_t               row_eff;
  row_t               wr_row;
  logic               mem_we;

  bk_state_t          state_r, state_nxt;
  q_item_t            q_item;
  q_item_t            cur_r, cur_nxt;
  logic [WI_W-1:0]    sel_r, sel_nxt;
  logic               hit_r, hit_nxt;
  logic               empty_r, empty_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  cand_t              cand_r [P];
  cand_t              cand_nxt [P];

  logic [STAMP_W-1:0] clk_cnt_r, clk_cnt_nxt;
  logic [CNT_W-1:0]   hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0]   miss_cnt_r, miss_cnt_nxt;
  logic [CNT_W-1:0]   evict_cnt_r, evict_cnt_nxt;
  logic [CNT_W-1:0]   hit_one;
  logic [STAMP_W-1:0] now;
  logic [WI_W-1:0]    victim;

  logic [MAX_WAYS-1:0] stop;
  logic               found;
  logic [WI_W-1:0]    first_sel;

  logic               out_vld_r;
  out_item_t          out_item_r, out_nxt;
  logic               out_load;
  logic               out_free;

  assign q_item    = q_data;
  assign row_eff   = rd_rowv_r ? rd_row_r : '0;
  assign out_free  = !out_vld_r || out_ready;
  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  // Set row memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_r.set] <= wr_row;
    end
    if (q_pop) begin
      rd_row_r <= mem[q_item.set];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rowv_r <= '0;
    end else if (mem_we) begin
      rowv_r[cur_r.set] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_rowv_r <= rowv_r[q_item.set];
    end
  end

  // Lookup: first way that is empty or matches
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      stop[w] = (w < int'(cur_r.ways)) &&
                (!row_eff[w].vld || (row_eff[w].tag == cur_r.tag));
    end
    found     = 1'b0;
    first_sel = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (stop[w]) begin
        found     = 1'b1;
        first_sel = WI_W'(w);
      end
    end
  end

  // Write back of the chosen line and counter updates
  always_comb begin
    now    = clk_cnt_r + STAMP_W'(1);
    victim = (hit_r || empty_r) ? sel_r : cand_r[0].idx;
    wr_row = row_eff;
    if (hit_r) begin
      wr_row[victim].stamp = now;
    end else begin
      wr_row[victim].vld   = 1'b1;
      wr_row[victim].tag   = cur_r.tag;
      wr_row[victim].stamp = now;
    end
    hit_one = sat_inc(hit_cnt_r, hit_r);
  end

  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    out_load      = 1'b0;
    out_nxt       = out_item_r;
    cur_nxt       = cur_r;
    sel_nxt       = sel_r;
    hit_nxt       = hit_r;
    empty_nxt     = empty_r;
    lvl_nxt       = lvl_r;
    cand_nxt      = cand_r;
    clk_cnt_nxt   = clk_cnt_r;
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    evict_cnt_nxt = evict_cnt_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_item;
          state_nxt = (q_item.op == OP_IFETCH) ? BK_WRITE : BK_CMP;
        end
      end
      BK_CMP: begin
        sel_nxt   = first_sel;
        hit_nxt   = found && row_eff[first_sel].vld;
        empty_nxt = found && !row_eff[first_sel].vld;
        lvl_nxt   = LVL_W'(LVLS);
        for (int i = 0; i < P; i++) begin
          cand_nxt[i].ok    = (i < MAX_WAYS) && (i < int'(cur_r.ways));
          cand_nxt[i].idx   = WI_W'(i);
          cand_nxt[i].stamp = row_eff[i % MAX_WAYS].stamp;
        end
        state_nxt = (found || (LVLS == 0)) ? BK_WRITE : BK_REDUCE;
      end
      BK_REDUCE: begin
        for (int i = 0; i < P / 2; i++) begin
          cand_nxt[i] = pick(cand_r[2*i], cand_r[2*i+1]);
        end
        for (int i = P / 2; i < P; i++) begin
          cand_nxt[i].ok = 1'b0;
        end
        lvl_nxt = lvl_r - LVL_W'(1);
        if (lvl_r == LVL_W'(1)) begin
          state_nxt = BK_WRITE;
        end
      end
      BK_WRITE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
          if (cur_r.op == OP_IFETCH) begin
            out_nxt.was_hit        = 1'b0;
            out_nxt.was_miss       = 1'b0;
            out_nxt.was_eviction   = 1'b0;
            out_nxt.extra_hit      = 1'b0;
            out_nxt.hit_total      = hit_cnt_r;
            out_nxt.miss_total     = miss_cnt_r;
            out_nxt.eviction_total = evict_cnt_r;
          end else begin
            mem_we        = 1'b1;
            clk_cnt_nxt   = now;
            hit_cnt_nxt   = sat_inc(hit_one, cur_r.op == OP_MODIFY);
            miss_cnt_nxt  = sat_inc(miss_cnt_r, !hit_r);
            evict_cnt_nxt = sat_inc(evict_cnt_r, !hit_r && !empty_r);
            out_nxt.was_hit        = hit_r;
            out_nxt.was_miss       = !hit_r;
            out_nxt.was_eviction   = !hit_r && !empty_r;
            out_nxt.extra_hit      = (cur_r.op == OP_MODIFY);
            out_nxt.hit_total      = hit_cnt_nxt;
            out_nxt.miss_total     = miss_cnt_nxt;
            out_nxt.eviction_total = evict_cnt_nxt;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      clk_cnt_r   <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clk_cnt_r   <= clk_cnt_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      evict_cnt_r <= evict_cnt_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    sel_r   <= sel_nxt;
    hit_r   <= hit_nxt;
    empty_r <= empty_nxt;
    lvl_r   <= lvl_nxt;
    cand_r  <= cand_nxt;
    if (out_load) begin
      out_item_r <= out_nxt;
    end
  end

  `SALCT_ASSERT(a_hit_miss_excl, clk, rst_n, !out_vld_r || !(out_item_r.was_hit && out_item_r.was_miss), "hit and miss both set")
  `SALCT_ASSERT(a_evict_is_miss, clk, rst_n, !out_vld_r || !out_item_r.was_eviction || out_item_r.was_miss, "eviction without miss")
  `SALCT_ASSERT(a_reduce_on_full, clk, rst_n, (state_r != BK_REDUCE) || (!hit_r && !empty_r), "LRU search on hit or fill")
  `SALCT_ASSERT_NEXT(a_hits_monotonic, clk, rst_n, state_r == BK_WRITE, hit_cnt_r >= $past(hit_cnt_r), "hit total went down")

endmodule

### hdl/set_assoc_lru_cache_tags.sv
// Top level of the set-associative cache tag store with LRU replacement.
//
//   channel  dir  handshake              payload
//   cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//   in       in   in_valid/in_ready      in_item (opcode, address)
//   out      out  out_valid/out_ready    out_item (flags and running totals)
//
// Back end: fetch goes idle to write, hit or fill via compare, eviction also via reduce:
// the LRU way is found by a halving stamp reduction, one level a cycle. The front end
// classifies in the accept cycle; a two-item queue lets it keep accepting while the back
// end works or waits on out_ready. Each item reads one set row; non-fetch ones write it
// back. Reset is synchronous; per-row valid flops clear the store at once, no clearing pass.
module set_assoc_lru_cache_tags #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_BITS    = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [salct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salct_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  salct_pkg::in_item_t              in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output salct_pkg::out_item_t             out_item
);
  import salct_pkg::*;

  localparam int QW = $clog2(MAX_WAYS + 1) + MAX_SET_BITS + ADDR_BITS;

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;

  salct_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  salct_fifo #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  salct_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

### bench/tb.sv
// Testbench for the LRU cache tag store: directed and random accesses checked against a predictor.
`timescale 1ns / 1ps

module tb;
  import salct_pkg::*;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int SETS         = 1 << MAX_SET_BITS;
  localparam int QUIET_LIMIT  = 4000;
  localparam int REPORT_MAX   = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;

  set_assoc_lru_cache_tags #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS    (MAX_WAYS),
    .ADDR_BITS   (64)
  ) DUT (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predictor state
  logic [SET_BITS_W-1:0] set_bits_reg = RST_SET_BITS;
  logic [OFFSET_W-1:0]   offset_reg   = RST_OFFSET;
  logic [WAYS_W-1:0]     ways_reg     = RST_WAYS;
  bit                    way_live  [SETS][MAX_WAYS];
  bit [63:0]             way_tag   [SETS][MAX_WAYS];
  bit [63:0]             way_stamp [SETS][MAX_WAYS];
  bit [63:0]             stamp_clock;
  bit [CNT_W-1:0]        hit_tally;
  bit [CNT_W-1:0]        miss_tally;
  bit [CNT_W-1:0]        evict_tally;

  in_item_t  pending_accesses[$];
  out_item_t expected_results[$];

  bit in_taken  = 1'b0;
  bit cfg_taken = 1'b0;
  bit steady    = 1'b1;
  int send_gap  = 0;
  int recv_stall = 0;
  int faults    = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  function automatic int eff_set_bits(logic [SET_BITS_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SET_BITS) return MAX_SET_BITS;
    return v;
  endfunction

  function automatic int eff_offset_bits(logic [OFFSET_W-1:0] v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int eff_ways(logic [WAYS_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_WAYS) return MAX_WAYS;
    return v;
  endfunction

  function automatic bit [CNT_W-1:0] bump(bit [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic out_item_t predict_access(in_item_t acc);
    int s, b, e, w, lru;
    bit found, empty;
    logic [63:0] set_sel, tag;
    out_item_t r;
    s = eff_set_bits(set_bits_reg);
    b = eff_offset_bits(offset_reg);
    e = eff_ways(ways_reg);
    r = '0;
    if (acc.opcode != OP_IFETCH) begin
      set_sel = (acc.address >> b) & ((64'd1 << s) - 64'd1);
      tag = acc.address >> (s + b);
      stamp_clock = stamp_clock + 64'd1;
      found = 1'b0;
      empty = 1'b0;
      lru = 0;
      for (w = 0; w < e; w++) begin
        if (!way_live[set_sel][w]) begin
          empty = 1'b1;
          break;
        end
        if (way_stamp[set_sel][w] < way_stamp[set_sel][lru]) lru = w;
        if (way_tag[set_sel][w] == tag) begin
          found = 1'b1;
          break;
        end
      end
      if (found) begin
        way_stamp[set_sel][w] = stamp_clock;
        r.was_hit = 1'b1;
        hit_tally = bump(hit_tally);
      end else begin
        if (!empty) begin
          w = lru;
          r.was_eviction = 1'b1;
          evict_tally = bump(evict_tally);
        end
        way_live[set_sel][w]  = 1'b1;
        way_tag[set_sel][w]   = tag;
        way_stamp[set_sel][w] = stamp_clock;
        r.was_miss = 1'b1;
        miss_tally = bump(miss_tally);
      end
      if (acc.opcode == OP_MODIFY) begin
        r.extra_hit = 1'b1;
        hit_tally = bump(hit_tally);
      end
    end
    r.hit_total      = hit_tally;
    r.miss_total     = miss_tally;
    r.eviction_total = evict_tally;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // access driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_accesses.size() != 0) begin
        in_item  <= pending_accesses.pop_front();
        in_valid <= 1'b1;
        send_gap <= steady ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink back-pressure
  always @(negedge clk) begin
    if (recv_stall != 0) begin
      out_ready  <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(0, 7) == 0) recv_stall <= pick_gap();
    end
  end

  // monitor, predictor and scoreboard
  always @(posedge clk) begin : monitor
    out_item_t want;
    bit progress;
    in_taken  <= rst_n && in_valid && in_ready;
    cfg_taken <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      progress = 1'b0;
      if (cfg_valid && cfg_ready) begin
        progress = 1'b1;
        case (cfg_index)
          CFG_SET_BITS:    set_bits_reg = cfg_data[SET_BITS_W-1:0];
          CFG_OFFSET_BITS: offset_reg   = cfg_data[OFFSET_W-1:0];
          CFG_WAYS:        ways_reg     = cfg_data[WAYS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        progress = 1'b1;
        expected_results.push_back(predict_access(in_item));
      end
      if (out_valid && out_ready) begin
        progress = 1'b1;
        results_seen++;
        if (expected_results.size() == 0) begin
          faults++;
          if (faults <= REPORT_MAX)
            $display("result %0d arrived with nothing expected", results_seen);
        end else begin
          want = expected_results.pop_front();
          if (out_item.was_hit !== want.was_hit || out_item.was_miss !== want.was_miss ||
              out_item.was_eviction !== want.was_eviction ||
              out_item.extra_hit !== want.extra_hit ||
              out_item.hit_total !== want.hit_total ||
              out_item.miss_total !== want.miss_total ||
              out_item.eviction_total !== want.eviction_total) begin
            faults++;
            if (faults <= REPORT_MAX)
              $display("result %0d: exp %b%b%b%b %0d/%0d/%0d, got %b%b%b%b %0d/%0d/%0d",
                       results_seen, want.was_hit, want.was_miss, want.was_eviction,
                       want.extra_hit, want.hit_total, want.miss_total, want.eviction_total,
                       out_item.was_hit, out_item.was_miss, out_item.was_eviction,
                       out_item.extra_hit, out_item.hit_total, out_item.miss_total,
                       out_item.eviction_total);
          end
        end
      end
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic queue_access(op_t op, logic [63:0] addr);
    in_item_t it;
    it.opcode  = op;
    it.address = addr;
    pending_accesses.push_back(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_all_answered();
    do @(negedge clk);
    while (pending_accesses.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // upper data bits are don't-care, so they carry noise
  task automatic set_geometry(int sb, int ob, int wb);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom_range(0, 255));
    write_reg(CFG_SET_BITS, (noise & 8'hF8) | sb[7:0]);
    noise = CFG_DATA_W'($urandom_range(0, 255));
    write_reg(CFG_OFFSET_BITS, (noise & 8'hE0) | ob[7:0]);
    noise = CFG_DATA_W'($urandom_range(0, 255));
    write_reg(CFG_WAYS, (noise & 8'hF0) | wb[7:0]);
  endtask

  task automatic run_phase(int sb, int ob, int wb, int count, int hot, int pool_n);
    logic [63:0] pool[$];
    logic [63:0] set_mask, blk_mask, a;
    int s, b, r;
    op_t op;
    set_geometry(sb, ob, wb);
    steady = ($urandom_range(0, 3) == 0);
    s = eff_set_bits(SET_BITS_W'(sb));
    b = eff_offset_bits(OFFSET_W'(ob));
    set_mask = (64'd1 << s) - 64'd1;
    blk_mask = (64'd1 << b) - 64'd1;
    for (int i = 0; i < pool_n; i++) begin
      a = {$urandom, $urandom};
      a = (a & ~(set_mask << b)) | ((64'($urandom_range(0, hot - 1)) & set_mask) << b);
      pool.push_back(a);
    end
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      op = (r < 35) ? OP_LOAD : (r < 65) ? OP_STORE : (r < 90) ? OP_MODIFY : OP_IFETCH;
      if ($urandom_range(0, 99) < 85) begin
        a = pool[$urandom_range(0, pool.size() - 1)];
        a = (a & ~blk_mask) | ({$urandom, $urandom} & blk_mask);
      end else begin
        a = {$urandom, $urandom};
      end
      queue_access(op, a);
    end
    wait_all_answered();
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset geometry: 16 sets, 16-byte blocks, direct mapped
    queue_access(OP_LOAD, 64'h0);
    queue_access(OP_LOAD, 64'h0);
    queue_access(OP_STORE, 64'hF);
    queue_access(OP_MODIFY, 64'h100);
    queue_access(OP_IFETCH, '1);
    queue_access(OP_LOAD, '1);
    queue_access(OP_MODIFY, '1);
    queue_access(OP_STORE, 64'h8000_0000_0000_0000);
    queue_access(OP_IFETCH, 64'h0);
    queue_access(OP_LOAD, 64'h100);
    wait_all_answered();

    // zero fields clamp to one; fill all eight ways of set 0, then check LRU order
    set_geometry(0, 0, MAX_WAYS);
    for (int i = 0; i < MAX_WAYS; i++) queue_access(OP_STORE, 64'(i * 4));
    queue_access(OP_LOAD, 64'h0);
    queue_access(OP_LOAD, 64'd32);
    queue_access(OP_LOAD, 64'd4);
    queue_access(OP_MODIFY, 64'd8);
    wait_all_answered();

    steady = 1'b0;
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 255)));
    run_phase(0, 0, 2, 80, 2, 6);
    run_phase(1, 1, 1, 100, 2, 4);
    run_phase(7, 31, 15, 100, 3, 30);
    run_phase(6, 16, 8, 120, 4, 40);
    run_phase(2, 5, 4, 100, 4, 20);
    run_phase(3, 17, 3, 100, 3, 12);
    for (int i = 0; i < 3; i++)
      run_phase($urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 15),
                85, $urandom_range(1, 4), $urandom_range(4, 24));

    wait_all_answered();
    repeat (20) @(posedge clk);
    if (faults == 0 && expected_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
